>>> src/ctp_pkg.sv
// ----------------------------------------------------------------------------
// ctp_pkg
// shared types and constants of the countdown timer pool
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int SLOT_W         = 4;
    localparam int OP_W           = 3;
    localparam int DELAY_W        = 32;
    localparam int STAMP_W        = 32;

    // fine tick step of the microsecond stamp
    localparam logic [STAMP_W-1:0] US_STEP = STAMP_W'(100);

    typedef enum logic [OP_W-1:0] {
        OP_MS_TICK   = 3'd0,
        OP_FINE_TICK = 3'd1,
        OP_ALLOC     = 3'd2,
        OP_RESTART   = 3'd3,
        OP_RELEASE   = 3'd4,
        OP_QUERY     = 3'd5
    } t_op;

    // per-cell command for one accepted beat
    typedef struct packed {
        logic tick;
        logic alloc;
        logic load;
        logic clear;
    } t_cell_cmd;

endpackage

>>> src/ctp_in_if.sv
// ----------------------------------------------------------------------------
// ctp_in_if
// request channel: op, slot and delay with valid/ready
// ----------------------------------------------------------------------------
interface ctp_in_if;
    import ctp_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [DELAY_W-1:0] delay_value;

    modport source (output valid, output op, output slot, output delay_value, input ready);
    modport sink   (input valid, input op, input slot, input delay_value, output ready);
endinterface

>>> src/ctp_out_if.sv
// ----------------------------------------------------------------------------
// ctp_out_if
// result channel: grant, failure, done flag and timestamps with valid/ready
// ----------------------------------------------------------------------------
interface ctp_out_if;
    import ctp_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  granted_slot;
    logic               alloc_failed;
    logic               slot_done;
    logic [STAMP_W-1:0] time_ms;
    logic [STAMP_W-1:0] time_us;

    modport source (
        output valid, output granted_slot, output alloc_failed, output slot_done,
        output time_ms, output time_us, input ready
    );
    modport sink (
        input valid, input granted_slot, input alloc_failed, input slot_done,
        input time_ms, input time_us, output ready
    );
endinterface

>>> src/ctp_cell.sv
// ----------------------------------------------------------------------------
// ctp_cell
// one timer slot: busy mark, countdown and done flag, plus a link of the
// allocate priority chain
// ----------------------------------------------------------------------------
module ctp_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ctp_pkg::t_cell_cmd         i_cmd,
    input  logic [ctp_pkg::DELAY_W-1:0] i_delay,
    input  logic                       i_claim,
    output logic                       o_claim,
    output logic                       o_take,
    output logic                       o_expired_next
);
    import ctp_pkg::*;

    logic               r_busy;
    logic               n_busy;
    logic [DELAY_W-1:0] r_count;
    logic [DELAY_W-1:0] n_count;
    logic               r_expired;
    logic               n_expired;

    // a free cell with no free cell below it takes the allocate
    assign o_take  = i_cmd.alloc && !i_claim && !r_busy;
    assign o_claim = i_claim || !r_busy;

    always_comb begin
        n_busy    = r_busy;
        n_count   = r_count;
        n_expired = r_expired;
        if (i_cmd.clear) begin
            n_busy    = 1'b0;
            n_count   = '0;
            n_expired = 1'b0;
        end else if (i_cmd.load || o_take) begin
            n_busy    = 1'b1;
            n_count   = i_delay;
            n_expired = 1'b0;
        end else if (i_cmd.tick && r_busy) begin
            if (r_count != '0) begin
                n_count = r_count - DELAY_W'(1);
            end
            if (r_count <= DELAY_W'(1)) begin
                n_expired = 1'b1;
            end
        end
    end

    assign o_expired_next = n_expired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_expired <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_expired <= n_expired;
        end
        r_count <= n_count;
    end

endmodule

>>> src/countdown_timer_pool.sv
// countdown_timer_pool: a bank of NUM_TIMERS countdown timers and two wrapping
// timestamps. Every request beat yields exactly one result beat, registered,
// valid the cycle after acceptance; a new request is taken each cycle as long
// as the result register is empty or being drained. This rests on the row of
// timer cells: each cell updates its slot in the accepting cycle, and the
// lowest-free-slot search for allocate ripples through the cells as a one-bit
// claim chain in that same cycle. A ms tick counts down every busy slot and
// raises done when its count reaches zero; a fine tick adds 100 to the
// microsecond stamp; restart and release touch the addressed slot only (slots
// at or above the pool size, or above 15, are ignored and read as not done).
// Codes six and seven behave as a query.
// ----------------------------------------------------------------------------
// countdown_timer_pool
// top level: request decode, row of timer cells, timestamps, result register
// ----------------------------------------------------------------------------
module countdown_timer_pool #(
    parameter int NUM_TIMERS = ctp_pkg::NUM_TIMERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ctp_in_if.sink         i_req,
    ctp_out_if.source      o_res
);
    import ctp_pkg::*;

    // request accepted this cycle
    logic acc;

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_granted;
    logic                  r_failed;
    logic                  r_done;
    logic [STAMP_W-1:0]    r_time_ms;
    logic [STAMP_W-1:0]    r_time_us;

    logic [STAMP_W-1:0]    n_time_ms;
    logic [STAMP_W-1:0]    n_time_us;
    logic [SLOT_W-1:0]     n_granted;
    logic                  n_failed;
    logic                  n_done;

    // claim chain: claim[i] means a free slot exists below cell i
    logic [NUM_TIMERS:0]   claim;
    logic [NUM_TIMERS-1:0] take;
    logic [NUM_TIMERS-1:0] sel;
    logic [NUM_TIMERS-1:0] exp_next;

    logic is_tick;
    logic is_fine;
    logic is_alloc;
    logic is_restart;
    logic is_release;

    // result register frees up when drained, so one beat per cycle
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign acc         = i_req.valid && i_req.ready;

    assign is_tick    = acc && (i_req.op == OP_MS_TICK);
    assign is_fine    = acc && (i_req.op == OP_FINE_TICK);
    assign is_alloc   = acc && (i_req.op == OP_ALLOC);
    assign is_restart = acc && (i_req.op == OP_RESTART);
    assign is_release = acc && (i_req.op == OP_RELEASE);

    assign claim[0] = 1'b0;

    // row of timer cells, lowest index has allocate priority
    for (genvar gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
        t_cell_cmd cmd;

        // slot field reaches only the first 2**SLOT_W cells
        assign sel[gi] = (gi < (1 << SLOT_W)) && (i_req.slot == SLOT_W'(gi));

        assign cmd.tick  = is_tick;
        assign cmd.alloc = is_alloc;
        assign cmd.load  = is_restart && sel[gi];
        assign cmd.clear = is_release && sel[gi];

        ctp_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd),
            .i_delay        (i_req.delay_value),
            .i_claim        (claim[gi]),
            .o_claim        (claim[gi+1]),
            .o_take         (take[gi]),
            .o_expired_next (exp_next[gi])
        );
    end

    // grant number from the single taking cell, low bits only
    always_comb begin
        n_granted = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (take[i]) begin
                n_granted = n_granted | SLOT_W'(i);
            end
        end
    end

    // pool full: no link of the chain saw a free slot
    assign n_failed = (i_req.op == OP_ALLOC) && !claim[NUM_TIMERS];

    // done flag after this item of the addressed slot, zero for allocate
    assign n_done = (i_req.op != OP_ALLOC) && |(sel & exp_next);

    assign n_time_ms = r_time_ms + (is_tick ? STAMP_W'(1) : '0);
    assign n_time_us = r_time_us + (is_fine ? US_STEP : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_time_ms   <= '0;
            r_time_us   <= '0;
        end else begin
            r_time_ms <= n_time_ms;
            r_time_us <= n_time_us;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (acc) begin
            r_granted <= n_granted;
            r_failed  <= n_failed;
            r_done    <= n_done;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.granted_slot = r_granted;
    assign o_res.alloc_failed = r_failed;
    assign o_res.slot_done    = r_done;
    assign o_res.time_ms      = r_time_ms;
    assign o_res.time_us      = r_time_us;

`ifndef SYNTH
    // at most one cell takes an allocate
    a_single_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(take))
        else $error("more than one cell took the allocate");

    // allocate with every slot busy reports failure in the next beat
    a_full_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_alloc && !claim[NUM_TIMERS]) |=> (o_res.valid && o_res.alloc_failed))
        else $error("full pool allocate not flagged");

    // a failed allocate carries neither grant nor done
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.alloc_failed) |->
            (o_res.granted_slot == '0 && !o_res.slot_done))
        else $error("failed allocate with grant or done set");

    // an accepted request always leaves a result beat
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted request left no result");

    // ms stamp moves only on a ms tick, by one
    a_ms_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_time_ms == $past(r_time_ms) + ($past(is_tick) ? STAMP_W'(1) : '0)))
        else $error("ms stamp stepped wrongly");
`endif

endmodule
